[sv/rmth_pkg.sv]
// Package with shared types and constants for the running median block.
`default_nettype none
package rmth_pkg;
    localparam int CAPACITY_DEF = 1024;
    localparam int SAMPLE_W = 32;
    localparam int MED_W = 33;
    localparam int COUNT_W = 11;

    typedef enum logic [1:0] {
        HEAP_LOWER = 2'd0,
        HEAP_UPPER = 2'd1
    } heap_sel_t;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP = 2'd1
    } heap_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH_LO,
        ST_WAIT1,
        ST_CHECK1,
        ST_MOVE_UP,
        ST_WAIT2,
        ST_CHECK2,
        ST_MOVE_DN,
        ST_WAIT3,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [3:0] {
        HS_IDLE,
        HS_UP_RD,
        HS_UP_CMP,
        HS_DN_RD,
        HS_DN_RD2,
        HS_DN_CMP,
        HS_ROOT_WR,
        HS_ROOT_RD,
        HS_DONE
    } heap_state_t;
endpackage
`default_nettype wire

[sv/rmth_heap.sv]
// One max-heap kept in a synchronous memory, with sift-up push and sift-down pop.
`default_nettype none
module rmth_heap #(
    parameter int DEPTH = rmth_pkg::CAPACITY_DEF / 2 + 2,
    parameter int IDX_W = $clog2(DEPTH + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire rmth_pkg::heap_op_t          op,
    input  wire logic signed [rmth_pkg::SAMPLE_W:0] key,
    output logic                             busy,
    output logic signed [rmth_pkg::SAMPLE_W:0] top,
    output logic signed [rmth_pkg::SAMPLE_W:0] popped,
    output logic [IDX_W-1:0]                 count
);
    import rmth_pkg::*;

    localparam int KW = SAMPLE_W + 1;

    logic signed [KW-1:0] mem [DEPTH];
    logic signed [KW-1:0] rd_a, rd_b;
    logic [IDX_W-1:0] ra_addr, rb_addr, wr_addr;
    logic signed [KW-1:0] wr_data;
    logic wr_en;

    heap_state_t state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic signed [KW-1:0] cur_reg, cur_next;
    logic signed [KW-1:0] top_reg, top_next;
    logic signed [KW-1:0] pop_reg, pop_next;
    logic [IDX_W:0] lidx, ridx;
    logic lok, rok;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a <= mem[ra_addr];
        rd_b <= mem[rb_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= HS_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cur_reg <= cur_next;
        top_reg <= top_next;
        pop_reg <= pop_next;
    end

    assign lidx = {idx_reg, 1'b1};
    assign ridx = {idx_reg, 1'b0} + (IDX_W+1)'(2);
    assign lok = lidx < {1'b0, cnt_reg};
    assign rok = ridx < {1'b0, cnt_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        cur_next = cur_reg;
        top_next = top_reg;
        pop_next = pop_reg;
        wr_en = 1'b0;
        wr_addr = idx_reg;
        wr_data = cur_reg;
        ra_addr = (idx_reg - IDX_W'(1)) >> 1;
        rb_addr = lidx[IDX_W-1:0];
        case (state_reg)
            HS_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_PUSH)
                    begin
                        wr_en = 1'b1;
                        wr_addr = cnt_reg;
                        wr_data = key;
                        idx_next = cnt_reg;
                        cur_next = key;
                        cnt_next = cnt_reg + IDX_W'(1);
                        if (cnt_reg == '0)
                        begin
                            top_next = key;
                            state_next = HS_DONE;
                        end
                        else
                        begin
                            ra_addr = (cnt_reg - IDX_W'(1)) >> 1;
                            state_next = HS_UP_CMP;
                        end
                    end
                    else
                    begin
                        pop_next = top_reg;
                        cnt_next = cnt_reg - IDX_W'(1);
                        ra_addr = cnt_reg - IDX_W'(1);
                        idx_next = '0;
                        state_next = HS_ROOT_RD;
                    end
                end
            end
            HS_UP_RD:
            begin
                ra_addr = (idx_reg - IDX_W'(1)) >> 1;
                state_next = HS_UP_CMP;
            end
            HS_UP_CMP:
            begin
                if (rd_a >= cur_reg)
                begin
                    state_next = HS_ROOT_WR;
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_addr = idx_reg;
                    wr_data = rd_a;
                    idx_next = (idx_reg - IDX_W'(1)) >> 1;
                    if (((idx_reg - IDX_W'(1)) >> 1) == '0)
                    begin
                        state_next = HS_ROOT_WR;
                    end
                    else
                    begin
                        state_next = HS_UP_RD;
                    end
                end
            end
            HS_ROOT_WR:
            begin
                wr_en = 1'b1;
                wr_addr = idx_reg;
                wr_data = cur_reg;
                if (idx_reg == '0)
                begin
                    top_next = cur_reg;
                end
                state_next = HS_DONE;
            end
            HS_ROOT_RD:
            begin
                cur_next = rd_a;
                if (cnt_reg == '0)
                begin
                    state_next = HS_DONE;
                end
                else
                begin
                    state_next = HS_DN_RD;
                end
            end
            HS_DN_RD:
            begin
                ra_addr = lidx[IDX_W-1:0];
                rb_addr = ridx[IDX_W-1:0];
                state_next = HS_DN_CMP;
            end
            HS_DN_CMP:
            begin
                if (lok && rd_a > cur_reg && !(rok && rd_b > rd_a))
                begin
                    wr_en = 1'b1;
                    wr_addr = idx_reg;
                    wr_data = rd_a;
                    if (idx_reg == '0)
                    begin
                        top_next = rd_a;
                    end
                    idx_next = lidx[IDX_W-1:0];
                    state_next = HS_DN_RD;
                end
                else if (rok && rd_b > cur_reg && !(lok && rd_a >= rd_b))
                begin
                    wr_en = 1'b1;
                    wr_addr = idx_reg;
                    wr_data = rd_b;
                    if (idx_reg == '0)
                    begin
                        top_next = rd_b;
                    end
                    idx_next = ridx[IDX_W-1:0];
                    state_next = HS_DN_RD;
                end
                else
                begin
                    state_next = HS_ROOT_WR;
                end
            end
            HS_DN_RD2:
            begin
                state_next = HS_DN_RD;
            end
            HS_DONE:
            begin
                state_next = HS_IDLE;
            end
            default:
            begin
                state_next = HS_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != HS_IDLE);
    assign top = top_reg;
    assign popped = pop_reg;
    assign count = cnt_reg;
endmodule
`default_nettype wire

[sv/running_median_two_heaps.sv]
// Top level of the running median block built from two memory-backed heaps.
// Each accepted sample transaction yields one result transaction carrying the median
// times two, the number of samples held and an overflow flag for a refused sample.
// A sample takes one insert into the lower heap and up to two moves between the
// heaps, each move a pop and a push, so at most five heap operations. Each heap
// operation is a sift through one memory, with a read and a compare at each tree
// level. A refused sample goes straight to the final step without touching the heaps.
// The block works on one sample at a time, and a result that is not taken holds the
// next sample back in its final step.
`default_nettype none
module running_median_two_heaps #(
    parameter int CAPACITY = rmth_pkg::CAPACITY_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [rmth_pkg::SAMPLE_W-1:0] sample,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [rmth_pkg::MED_W-1:0]       median_half_units,
    output logic [rmth_pkg::COUNT_W-1:0]            sample_count,
    output logic                                    overflow
);
    import rmth_pkg::*;

    localparam int DEPTH = CAPACITY / 2 + 2;
    localparam int IDX_W = $clog2(DEPTH + 1);
    localparam int KW = SAMPLE_W + 1;

    ctrl_state_t state_reg, state_next;
    logic lo_start, up_start;
    heap_op_t lo_op, up_op;
    logic signed [KW-1:0] lo_key, up_key;
    logic lo_busy, up_busy;
    logic signed [KW-1:0] lo_top, up_top, lo_pop, up_pop;
    logic [IDX_W-1:0] lo_cnt, up_cnt;
    logic signed [KW-1:0] samp_reg, samp_next;
    logic ovf_reg, ovf_next;
    logic ovf_out_reg, ovf_out_next;
    logic out_valid_reg, out_valid_next;
    logic signed [MED_W-1:0] med_reg, med_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W:0] total;
    logic signed [MED_W-1:0] med_now;

    rmth_heap #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_lower (
        .clk(clk), .rst_n(rst_n), .start(lo_start), .op(lo_op), .key(lo_key),
        .busy(lo_busy), .top(lo_top), .popped(lo_pop), .count(lo_cnt)
    );

    rmth_heap #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_upper (
        .clk(clk), .rst_n(rst_n), .start(up_start), .op(up_op), .key(up_key),
        .busy(up_busy), .top(up_top), .popped(up_pop), .count(up_cnt)
    );

    assign total = {1'b0, lo_cnt} + {1'b0, up_cnt};

    always_comb
    begin
        if (lo_cnt == '0 && up_cnt == '0)
        begin
            med_now = '0;
        end
        else if (lo_cnt == up_cnt)
        begin
            med_now = MED_W'(lo_top - up_top);
        end
        else if (lo_cnt > up_cnt)
        begin
            med_now = MED_W'(lo_top) <<< 1;
        end
        else
        begin
            med_now = (-MED_W'(up_top)) <<< 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg <= samp_next;
        ovf_reg <= ovf_next;
        ovf_out_reg <= ovf_out_next;
        med_reg <= med_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        samp_next = samp_reg;
        ovf_next = ovf_reg;
        ovf_out_next = ovf_out_reg;
        med_next = med_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg;
        lo_start = 1'b0;
        up_start = 1'b0;
        lo_op = OP_PUSH;
        up_op = OP_PUSH;
        lo_key = samp_reg;
        up_key = -lo_pop;
        in_ready = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    samp_next = KW'(sample);
                    if (total >= (IDX_W+1)'(CAPACITY))
                    begin
                        ovf_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ovf_next = 1'b0;
                        state_next = ST_PUSH_LO;
                    end
                end
            end
            ST_PUSH_LO:
            begin
                lo_start = 1'b1;
                state_next = ST_WAIT1;
            end
            ST_WAIT1:
            begin
                if (!lo_busy)
                begin
                    state_next = ST_CHECK1;
                end
            end
            ST_CHECK1:
            begin
                if (lo_cnt > up_cnt + IDX_W'(1) || (up_cnt != '0 && lo_top > -up_top))
                begin
                    lo_start = 1'b1;
                    lo_op = OP_POP;
                    state_next = ST_MOVE_UP;
                end
                else
                begin
                    state_next = ST_CHECK2;
                end
            end
            ST_MOVE_UP:
            begin
                if (!lo_busy)
                begin
                    up_start = 1'b1;
                    up_key = -lo_pop;
                    state_next = ST_WAIT2;
                end
            end
            ST_WAIT2:
            begin
                if (!up_busy)
                begin
                    state_next = ST_CHECK2;
                end
            end
            ST_CHECK2:
            begin
                if (up_cnt > lo_cnt + IDX_W'(1))
                begin
                    up_start = 1'b1;
                    up_op = OP_POP;
                    state_next = ST_MOVE_DN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MOVE_DN:
            begin
                if (!up_busy)
                begin
                    lo_start = 1'b1;
                    lo_key = -up_pop;
                    state_next = ST_WAIT3;
                end
            end
            ST_WAIT3:
            begin
                if (!lo_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    med_next = med_now;
                    cnt_next = COUNT_W'(total);
                    ovf_out_next = ovf_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign median_half_units = med_reg;
    assign sample_count = cnt_reg;
    assign overflow = ovf_out_reg;
endmodule
`default_nettype wire

[sv/rmth_checker.sv]
// Port-level checker for the running median block and its bind statement.
`default_nettype none
module rmth_sva_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [10:0] sample_count,
    input wire logic        overflow
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while one is in work");
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_count != 11'd0)
        else $error("result with empty set");
    a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> sample_count >= 11'd2)
        else $error("overflow with a small count");
endmodule

bind running_median_two_heaps rmth_sva_checker u_rmth_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample_count(sample_count), .overflow(overflow)
);
`default_nettype wire
